>>> hdl/multilevel_queue_scheduler_macros.svh
// ----------------------------------------------------------------------------
// Multilevel queue scheduler assertion macros
// Shorthand for the clocked checks used in the scheduler RTL.
// ----------------------------------------------------------------------------
`ifndef MULTILEVEL_QUEUE_SCHEDULER_MACROS_SVH
`define MULTILEVEL_QUEUE_SCHEDULER_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define MLQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define MLQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/mlq_pkg.sv
// ----------------------------------------------------------------------------
// Multilevel queue scheduler package
// Field widths, codes and the controller state type.
// ----------------------------------------------------------------------------
package mlq_pkg;

  localparam int BURST_W    = 12;
  localparam int PRIO_W     = 8;
  localparam int LVLNUM_W   = 3;
  localparam int ID_W       = 4;
  localparam int OUT_TIME_W = 16;
  localparam int SLICE_W    = 8;
  localparam int CFG_LEVELS = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 72;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE_BASE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUANT_BASE = 3'd4;

  localparam logic REQ_ADD  = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  localparam logic [1:0] MODE_RR     = 2'd0;
  localparam logic [1:0] MODE_SJF    = 2'd1;
  localparam logic [1:0] MODE_SRTF   = 2'd2;
  localparam logic [1:0] MODE_RR_ALT = 2'd3;

  localparam logic [1:0] ST_RAN      = 2'd0;
  localparam logic [1:0] ST_IDLETICK = 2'd1;
  localparam logic [1:0] ST_ADD_OK   = 2'd2;
  localparam logic [1:0] ST_ADD_REJ  = 2'd3;

  localparam logic [1:0] MODE_RST [CFG_LEVELS] = '{MODE_RR, MODE_RR, MODE_RR, MODE_SJF};
  localparam logic [SLICE_W-1:0] QUANT_RST [CFG_LEVELS] = '{8'd1, 8'd3, 8'd4, 8'd1};

  typedef enum logic [3:0] {
    FSM_IDLE,
    FSM_ADD,
    FSM_REL,
    FSM_SEL,
    FSM_SCAN_F,
    FSM_SCAN_T,
    FSM_SCAN_C,
    FSM_REMOVE,
    FSM_SHIFT_R,
    FSM_SHIFT_W,
    FSM_GRANT,
    FSM_RUN_RD,
    FSM_RUN
  } fsm_t;

endpackage

>>> hdl/multilevel_queue_scheduler.sv
// ----------------------------------------------------------------------------
// Multilevel queue scheduler
// Task table and level FIFOs in RAM, sequenced by one controller.
// ----------------------------------------------------------------------------
// Channel  Dir  Signals                       Beat contents
// s_*      in   s_tvalid s_tready s_tdata     add-task request or one tick
// m_*      out  m_tvalid m_tready m_tdata     one result per request
// cfg_*    in   cfg_we cfg_index cfg_data     policy and quantum registers
//
// An add request runs ADD; a tick keeping the running task runs REL, RUN_RD,
// RUN. A selecting tick runs REL if a task ran, SEL, SCAN_F/T/C per entry
// scanned in the served level (one for round robin), REMOVE, a SHIFT_R/W
// pair per entry moved up when the pick leaves mid-FIFO, GRANT, RUN_RD, RUN.
// Reset is synchronous and needs no clearing pass. A stalled result holds the
// controller in its final state; the next request is taken once it leaves.
// ----------------------------------------------------------------------------
`include "multilevel_queue_scheduler_macros.svh"

module multilevel_queue_scheduler #(
  parameter int MAX_TASKS = 16,
  parameter int NUM_LEVELS = 4,
  parameter int TIME_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // task_id, burst_time, level_number, task_priority
  input  logic [mlq_pkg::IN_DATA_W-1:0]      s_tdata,
  // req_type
  input  logic                               s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // run_id, finished, completion_time, turnaround, waiting, response
  output logic [mlq_pkg::OUT_DATA_W-1:0]     m_tdata,
  // status
  output logic [1:0]                         m_tuser,
  input  logic                               cfg_we,
  input  logic [mlq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mlq_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import mlq_pkg::*;

  localparam int IW  = $clog2(MAX_TASKS);
  localparam int CW  = $clog2(MAX_TASKS + 1);
  localparam int LW  = $clog2(NUM_LEVELS);
  localparam int FD  = NUM_LEVELS * MAX_TASKS;
  localparam int FAW = $clog2(FD);
  localparam int TW  = TIME_BITS;
  localparam int R_LO = BURST_W;
  localparam int P_LO = 2 * BURST_W;
  localparam int A_LO = P_LO + PRIO_W;
  localparam int S_LO = A_LO + TW;
  localparam int TWW  = S_LO + TW;
  localparam logic [TW-1:0] TIME_TOP = {TW{1'b1}};

  function automatic logic [IW-1:0] wrap(input logic [IW-1:0] base, input logic [CW-1:0] k);
    logic [CW:0] s;
    s = (CW+1)'(base) + (CW+1)'(k);
    if (s >= (CW+1)'(MAX_TASKS)) begin
      s = s - (CW+1)'(MAX_TASKS);
    end
    return s[IW-1:0];
  endfunction

  function automatic logic [FAW-1:0] faddr(input logic [LW-1:0] lv, input logic [IW-1:0] slot);
    return FAW'(32'(lv) * MAX_TASKS + 32'(slot));
  endfunction

  function automatic logic [1:0] creg(input logic [LW-1:0] lv);
    return (32'(lv) > CFG_LEVELS - 1) ? 2'(CFG_LEVELS - 1) : 2'(lv);
  endfunction

  function automatic logic [OUT_TIME_W-1:0] t16(input logic [TW-1:0] v);
    return OUT_TIME_W'(v);
  endfunction

  fsm_t state, state_next;

  logic [1:0]         mode_r  [CFG_LEVELS];
  logic [SLICE_W-1:0] quant_r [CFG_LEVELS];

  logic [ID_W-1:0]     req_id;
  logic [BURST_W-1:0]  req_burst;
  logic [LVLNUM_W-1:0] req_lvl;
  logic [PRIO_W-1:0]   req_prio;

  logic [MAX_TASKS-1:0] slot_valid;
  logic [MAX_TASKS-1:0] started;
  logic [IW-1:0]        heads  [NUM_LEVELS];
  logic [CW-1:0]        counts [NUM_LEVELS];
  logic [IW-1:0]        cur;
  logic                 in_service;
  logic [LW-1:0]        svc_lv;
  logic [SLICE_W-1:0]   slice;
  logic [TW-1:0]        time_now;

  logic [LW-1:0]      sel_lv;
  logic [CW-1:0]      scan_i;
  logic [CW-1:0]      scan_n;
  logic [CW-1:0]      shift_k;
  logic [IW-1:0]      cand_id;
  logic [IW-1:0]      best_id;
  logic [CW-1:0]      best_pos;
  logic [BURST_W-1:0] best_key;
  logic [PRIO_W-1:0]  best_prio;
  logic [TW-1:0]      best_arr;

  logic [1:0]            o_status;
  logic [ID_W-1:0]       o_run_id;
  logic                  o_fin;
  logic [OUT_TIME_W-1:0] o_ct, o_tat, o_wt, o_rsp;

  logic           t_we, t_re;
  logic [IW-1:0]  t_waddr, t_raddr;
  logic [TWW-1:0] t_wdata, t_rdata;
  logic           f_we, f_re;
  logic [FAW-1:0] f_waddr, f_raddr;
  logic [IW-1:0]  f_wdata, f_rdata;

  mlq_ram #(.W(TWW), .D(MAX_TASKS)) u_task_ram (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .re(t_re), .raddr(t_raddr), .rdata(t_rdata)
  );

  mlq_ram #(.W(IW), .D(FD)) u_fifo_ram (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
    .re(f_re), .raddr(f_raddr), .rdata(f_rdata)
  );

  logic          out_ok;
  logic          out_load;
  logic [IW-1:0] add_idx;
  logic [LW-1:0] add_lv;
  logic          add_ok;
  logic [1:0]    m_svc;
  logic [SLICE_W-1:0] q_svc;
  logic          higher_wait;
  logic          release_now;
  logic          sel_found;
  logic [LW-1:0] sel_lv_c;
  logic [1:0]    m_sel;
  logic          m_sel_short;
  logic          scan_last;
  logic          shift_more;
  logic [BURST_W-1:0] c_burst, c_rem, c_key, rem_new;
  logic [PRIO_W-1:0]  c_prio;
  logic [TW-1:0]      c_arr, c_start, start_new, time_next, tat, wt;
  logic               beats;
  logic               fin;

  assign out_ok   = !m_tvalid || m_tready;
  assign out_load = out_ok && ((state == FSM_ADD) || (state == FSM_RUN)
                               || (state == FSM_SEL && !sel_found));
  assign add_idx = IW'(32'(req_id));
  assign add_lv  = LW'(req_lvl - LVLNUM_W'(1));
  assign add_ok  = (req_burst != '0) && (req_lvl != '0) && (32'(req_lvl) <= NUM_LEVELS)
                   && (32'(req_id) < MAX_TASKS) && !slot_valid[add_idx]
                   && (32'(counts[add_lv]) < MAX_TASKS);

  assign m_svc = mode_r[creg(svc_lv)];
  assign q_svc = (quant_r[creg(svc_lv)] == '0) ? SLICE_W'(1) : quant_r[creg(svc_lv)];

  always_comb begin
    higher_wait = 1'b0;
    sel_found   = 1'b0;
    sel_lv_c    = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (i < 32'(svc_lv) && counts[i] != '0) begin
        higher_wait = 1'b1;
      end
      if (counts[i] != '0) begin
        sel_found = 1'b1;
        sel_lv_c  = LW'(i);
      end
    end
  end

  assign release_now = (m_svc == MODE_SRTF)
                       || ((m_svc != MODE_SJF) && (slice >= q_svc || higher_wait));

  assign m_sel       = mode_r[creg(sel_lv)];
  assign m_sel_short = (m_sel == MODE_SJF) || (m_sel == MODE_SRTF);
  assign scan_last   = ((CW+1)'(scan_i) + (CW+1)'(1)) == (CW+1)'(scan_n);
  assign shift_more  = ((CW+1)'(shift_k) + (CW+1)'(1)) < (CW+1)'(counts[sel_lv]);

  assign c_burst = t_rdata[BURST_W-1:0];
  assign c_rem   = t_rdata[R_LO +: BURST_W];
  assign c_prio  = t_rdata[P_LO +: PRIO_W];
  assign c_arr   = t_rdata[A_LO +: TW];
  assign c_start = t_rdata[S_LO +: TW];
  assign c_key   = (m_sel == MODE_SRTF) ? c_rem : c_burst;

  assign beats = (c_key < best_key)
                 || (c_key == best_key && (c_prio > best_prio
                 || (c_prio == best_prio && (c_arr < best_arr
                 || (c_arr == best_arr && cand_id < best_id)))));

  assign rem_new   = (c_rem != '0) ? c_rem - BURST_W'(1) : c_rem;
  assign start_new = started[cur] ? c_start : time_now;
  assign time_next = (time_now < TIME_TOP) ? time_now + TW'(1) : time_now;
  assign tat       = time_next - c_arr;
  assign wt        = (32'(tat) > 32'(c_burst)) ? tat - TW'(c_burst) : '0;
  assign fin       = (rem_new == '0);

  always_comb begin
    state_next = state;
    t_we = 1'b0; t_waddr = cur; t_wdata = t_rdata;
    t_re = 1'b0; t_raddr = cur;
    f_we = 1'b0; f_waddr = '0; f_wdata = cur;
    f_re = 1'b0; f_raddr = '0;
    case (state)
      FSM_IDLE: begin
        if (s_tvalid) begin
          if (s_tuser == REQ_ADD) begin
            state_next = FSM_ADD;
          end else if (in_service) begin
            state_next = FSM_REL;
          end else begin
            state_next = FSM_SEL;
          end
        end
      end
      FSM_ADD: begin
        if (out_ok) begin
          state_next = FSM_IDLE;
          if (add_ok) begin
            t_we    = 1'b1;
            t_waddr = add_idx;
            t_wdata = {TW'(0), time_now, req_prio, req_burst, req_burst};
            f_we    = 1'b1;
            f_waddr = faddr(add_lv, wrap(heads[add_lv], counts[add_lv]));
            f_wdata = add_idx;
          end
        end
      end
      FSM_REL: begin
        if (release_now) begin
          f_we       = 1'b1;
          f_waddr    = faddr(svc_lv, wrap(heads[svc_lv], counts[svc_lv]));
          f_wdata    = cur;
          state_next = FSM_SEL;
        end else begin
          state_next = FSM_RUN_RD;
        end
      end
      FSM_SEL: begin
        if (sel_found) begin
          state_next = FSM_SCAN_F;
        end else if (out_ok) begin
          state_next = FSM_IDLE;
        end
      end
      FSM_SCAN_F: begin
        f_re       = 1'b1;
        f_raddr    = faddr(sel_lv, wrap(heads[sel_lv], scan_i));
        state_next = FSM_SCAN_T;
      end
      FSM_SCAN_T: begin
        t_re       = 1'b1;
        t_raddr    = f_rdata;
        state_next = FSM_SCAN_C;
      end
      FSM_SCAN_C: begin
        state_next = scan_last ? FSM_REMOVE : FSM_SCAN_F;
      end
      FSM_REMOVE: begin
        state_next = (best_pos == '0) ? FSM_GRANT : FSM_SHIFT_R;
      end
      FSM_SHIFT_R: begin
        if (shift_more) begin
          f_re       = 1'b1;
          f_raddr    = faddr(sel_lv, wrap(heads[sel_lv], shift_k + CW'(1)));
          state_next = FSM_SHIFT_W;
        end else begin
          state_next = FSM_GRANT;
        end
      end
      FSM_SHIFT_W: begin
        f_we       = 1'b1;
        f_waddr    = faddr(sel_lv, wrap(heads[sel_lv], shift_k));
        f_wdata    = f_rdata;
        state_next = FSM_SHIFT_R;
      end
      FSM_GRANT: begin
        state_next = FSM_RUN_RD;
      end
      FSM_RUN_RD: begin
        t_re       = 1'b1;
        state_next = FSM_RUN;
      end
      FSM_RUN: begin
        if (out_ok) begin
          t_we       = 1'b1;
          t_wdata    = {start_new, c_arr, c_prio, rem_new, c_burst};
          state_next = FSM_IDLE;
        end
      end
      default: begin
        state_next = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FSM_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CFG_LEVELS; i++) begin
        mode_r[i]  <= MODE_RST[i];
        quant_r[i] <= QUANT_RST[i];
      end
    end else if (cfg_we) begin
      if (cfg_index >= CFG_QUANT_BASE) begin
        quant_r[2'(cfg_index - CFG_QUANT_BASE)] <= cfg_data;
      end else begin
        mode_r[2'(cfg_index)] <= cfg_data[1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      started    <= '0;
      cur        <= '0;
      in_service <= 1'b0;
      svc_lv     <= '0;
      slice      <= '0;
      time_now   <= '0;
      m_tvalid   <= 1'b0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        heads[i]  <= '0;
        counts[i] <= '0;
      end
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        FSM_IDLE: begin
          if (s_tvalid) begin
            req_id    <= s_tdata[ID_W-1:0];
            req_burst <= s_tdata[ID_W +: BURST_W];
            req_lvl   <= s_tdata[ID_W + BURST_W +: LVLNUM_W];
            req_prio  <= s_tdata[ID_W + BURST_W + LVLNUM_W +: PRIO_W];
          end
        end
        FSM_ADD: begin
          if (out_ok) begin
            o_status <= add_ok ? ST_ADD_OK : ST_ADD_REJ;
            o_run_id <= '0;
            o_fin    <= 1'b0;
            o_ct     <= '0;
            o_tat    <= '0;
            o_wt     <= '0;
            o_rsp    <= '0;
            if (add_ok) begin
              slot_valid[add_idx] <= 1'b1;
              started[add_idx]    <= 1'b0;
              counts[add_lv]      <= counts[add_lv] + CW'(1);
            end
          end
        end
        FSM_REL: begin
          if (release_now) begin
            counts[svc_lv] <= counts[svc_lv] + CW'(1);
            in_service     <= 1'b0;
          end
        end
        FSM_SEL: begin
          if (sel_found) begin
            sel_lv <= sel_lv_c;
            scan_i <= '0;
            if (mode_r[creg(sel_lv_c)] == MODE_SJF || mode_r[creg(sel_lv_c)] == MODE_SRTF) begin
              scan_n <= counts[sel_lv_c];
            end else begin
              scan_n <= CW'(1);
            end
          end else if (out_ok) begin
            time_now <= time_next;
            o_status <= ST_IDLETICK;
            o_run_id <= '0;
            o_fin    <= 1'b0;
            o_ct     <= t16(time_next);
            o_tat    <= '0;
            o_wt     <= '0;
            o_rsp    <= '0;
          end
        end
        FSM_SCAN_T: begin
          cand_id <= f_rdata;
        end
        FSM_SCAN_C: begin
          if (scan_i == '0 || (m_sel_short && beats)) begin
            best_id   <= cand_id;
            best_pos  <= scan_i;
            best_key  <= c_key;
            best_prio <= c_prio;
            best_arr  <= c_arr;
          end
          scan_i <= scan_i + CW'(1);
        end
        FSM_REMOVE: begin
          if (best_pos == '0) begin
            heads[sel_lv]  <= wrap(heads[sel_lv], CW'(1));
            counts[sel_lv] <= counts[sel_lv] - CW'(1);
          end else begin
            shift_k <= best_pos;
          end
        end
        FSM_SHIFT_R: begin
          if (!shift_more) begin
            counts[sel_lv] <= counts[sel_lv] - CW'(1);
          end
        end
        FSM_SHIFT_W: begin
          shift_k <= shift_k + CW'(1);
        end
        FSM_GRANT: begin
          cur        <= best_id;
          svc_lv     <= sel_lv;
          slice      <= '0;
          in_service <= 1'b1;
        end
        FSM_RUN: begin
          if (out_ok) begin
            time_now     <= time_next;
            slice        <= (slice != {SLICE_W{1'b1}}) ? slice + SLICE_W'(1) : slice;
            started[cur] <= !fin;
            o_status     <= ST_RAN;
            o_run_id     <= ID_W'(32'(cur));
            o_fin        <= fin;
            o_ct         <= t16(time_next);
            o_tat        <= fin ? t16(tat) : '0;
            o_wt         <= fin ? t16(wt) : '0;
            o_rsp        <= fin ? t16(start_new - c_arr) : '0;
            if (fin) begin
              slot_valid[cur] <= 1'b0;
              in_service      <= 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign s_tready = (state == FSM_IDLE);
  assign m_tuser  = o_status;
  assign m_tdata  = {3'b000, o_rsp, o_wt, o_tat, o_ct, o_fin, o_run_id};

  `MLQ_ASSERT_IMP(a_service_live, in_service, slot_valid[cur], "task in service has no live slot")
  `MLQ_ASSERT_NEXT(a_one_request, s_tvalid && s_tready, !s_tready, "second request taken while busy")
  `MLQ_ASSERT_IMP(a_scan_bound, state == FSM_SCAN_C, scan_i < scan_n, "scan ran past the queue")
  `MLQ_ASSERT_NEXT(a_time_mono, 1'b1, time_now >= $past(time_now), "time went backwards")

endmodule

>>> hdl/mlq_ram.sv
// ----------------------------------------------------------------------------
// Scheduler RAM
// Simple dual-port synchronous memory, one write and one registered read.
// ----------------------------------------------------------------------------
module mlq_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
